// ===== rtl/q16au_pkg.sv =====
// ----------------------------------------------------------------------------
// q16au_pkg
// Shared types and constants of the Q16.16 arithmetic unit.
// ----------------------------------------------------------------------------
package q16au_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned MANT_BITS     = 23;
    localparam int unsigned EXP_BIAS      = 127;

    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_DIV  = 2'd1,
        CMD_ABS  = 2'd2,
        CMD_F2FX = 2'd3
    } cmd_t;

    // One pipeline slot: divider state plus the early result of other commands
    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        neg;
        logic        err;
        logic [31:0] res;
        logic [31:0] rem;
        logic [31:0] divisor;
        logic [31:0] low;
        logic [31:0] quot;
    } stage_t;

endpackage

// ===== rtl/q16au_prep.sv =====
// ----------------------------------------------------------------------------
// q16au_prep
// First stage: multiply, abs, float conversion and divider set-up.
// ----------------------------------------------------------------------------
module q16au_prep #(
    parameter int unsigned FRAC_BITS = q16au_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  q16au_pkg::cmd_t      cmd,
    input  logic signed [31:0]   operand_a,
    input  logic signed [31:0]   operand_b,
    output q16au_pkg::stage_t    stage_out
);
    import q16au_pkg::*;

    localparam int unsigned MSHIFT = MANT_BITS - FRAC_BITS;

    stage_t             st_reg;
    stage_t             st_next;
    logic signed [63:0] prod;
    logic        [31:0] mag_a;
    logic        [31:0] mag_b;
    logic        [31:0] hi;
    logic signed [9:0]  dexp;
    logic        [9:0]  ndexp;
    logic        [23:0] mant;
    logic        [31:0] fx;

    always_comb begin
        prod  = 64'(operand_a) * 64'(operand_b);
        mag_a = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
        mag_b = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);
        hi    = mag_a >> (DATA_W - FRAC_BITS);

        mant  = {1'b1, operand_a[22:0]};
        dexp  = $signed({2'b00, operand_a[30:23]}) - 10'(EXP_BIAS) - 10'(MSHIFT);
        ndexp = 10'(-dexp);
        if (dexp > 0) begin
            fx = (dexp >= 10'sd32) ? 32'd0 : ({8'd0, mant} << dexp[4:0]);
        end else if (dexp < 0) begin
            fx = (ndexp >= 10'd32) ? 32'd0 : ({8'd0, mant} >> ndexp[4:0]);
        end else begin
            fx = {8'd0, mant};
        end
        if (operand_a[31]) begin
            fx = 32'd0 - fx;
        end

        st_next.valid   = in_valid;
        st_next.is_div  = (cmd == CMD_DIV);
        st_next.neg     = operand_a[31] ^ operand_b[31];
        // quotient of 2^32 or more, or a zero divisor
        st_next.err     = (cmd == CMD_DIV) && ((mag_b == 32'd0) || (hi >= mag_b));
        st_next.rem     = hi;
        st_next.divisor = mag_b;
        st_next.low     = {mag_a[DATA_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
        st_next.quot    = 32'd0;
        case (cmd)
            CMD_MUL: st_next.res = prod[FRAC_BITS+31:FRAC_BITS];
            CMD_ABS: st_next.res = mag_a & 32'h7fff_ffff;
            CMD_F2FX: st_next.res = fx;
            default: st_next.res = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign stage_out = st_reg;

endmodule

// ===== rtl/q16au_div_stage.sv =====
// ----------------------------------------------------------------------------
// q16au_div_stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module q16au_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  q16au_pkg::stage_t stage_in,
    output q16au_pkg::stage_t stage_out
);
    import q16au_pkg::*;

    stage_t      st_reg;
    stage_t      st_next;
    logic [32:0] trial;
    logic        fits;

    always_comb begin
        st_next  = stage_in;
        trial    = {stage_in.rem, stage_in.low[31]};
        fits     = trial >= {1'b0, stage_in.divisor};
        st_next.rem  = fits ? 32'(trial - {1'b0, stage_in.divisor}) : trial[31:0];
        st_next.low  = {stage_in.low[30:0], 1'b0};
        st_next.quot = {stage_in.quot[30:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign stage_out = st_reg;

endmodule

// ===== rtl/q16_fixed_point_arith_unit_top.sv =====
// From input transfer to result valid an item passes the prep register (loaded
// at the transfer edge), then the 32 divide step registers and the output register,
// along the same path for every command.
// Throughput: one item per cycle while m_ready does not hold the pipeline; the 32-stage restoring divider sets depth.
// The whole pipeline holds while a result waits and m_ready is low.
// Reset (aresetn, synchronous, active low) clears all valid bits.
// ----------------------------------------------------------------------------
// q16_fixed_point_arith_unit_top
// Pipelined signed Q16.16 multiply, divide, abs and float-to-fixed unit.
// ----------------------------------------------------------------------------
module q16_fixed_point_arith_unit_top #(
    parameter int unsigned FRAC_BITS = q16au_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  q16au_pkg::cmd_t    s_cmd,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result,
    output logic               m_error
);
    import q16au_pkg::*;

    localparam int unsigned STEPS = DATA_W;

    stage_t      stg [STEPS+1];
    logic        en;
    logic        m_valid_reg;
    logic [31:0] m_result_reg;
    logic        m_error_reg;
    logic [31:0] res_next;
    logic        err_next;
    stage_t      last;

    // advance whenever the output slot is free or being drained
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    q16au_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .cmd       (s_cmd),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .stage_out (stg[0])
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_div
        q16au_div_stage u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_in  (stg[i]),
            .stage_out (stg[i+1])
        );
    end

    assign last = stg[STEPS];

    always_comb begin
        res_next = last.res;
        err_next = 1'b0;
        if (last.is_div) begin
            if (last.err) begin
                err_next = 1'b1;
            end else if (last.neg) begin
                err_next = last.quot > 32'h8000_0000;
            end else begin
                err_next = last.quot[31];
            end
            res_next = err_next ? 32'd0 : (last.neg ? 32'd0 - last.quot : last.quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg  <= last.valid;
            m_result_reg <= res_next;
            m_error_reg  <= err_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = $signed(m_result_reg);
    assign m_error  = m_error_reg;

endmodule
